### design/fvn_pkg.sv
// fvn_pkg: shared constants, types and helper function for the fractal value noise block
// no dependencies
package fvn_pkg;

  localparam int unsigned Octaves  = 4;
  localparam int unsigned FracBits = 16;
  localparam int unsigned CoordW   = 21;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned QW       = FracBits + 1;

  localparam logic [31:0] HashMx   = 32'd374761393;
  localparam logic [31:0] HashMz   = 32'd668265263;
  localparam logic [31:0] HashMs   = 32'd1442695041;
  localparam logic [31:0] HashMf   = 32'd1274126177;
  localparam logic [31:0] SeedStep = 32'd97;

  typedef enum logic [CfgIdxW-1:0] {
    RegHeightBase = 0,
    RegHeightRange = 1,
    RegSeedBase = 2,
    RegBaseFreq = 3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [7:0] height_base;
    logic [5:0]        height_range;
    logic [31:0]       seed_base;
    logic [15:0]       base_frequency;
  } cfg_t;

  // result of the per-octave lerp, Q(FracBits)
  typedef logic [QW-1:0] q_t;

  function automatic logic [FracBits-1:0] to_q(input logic [15:0] v);
    logic [23:0] w;
    w = {v, 8'd0};
    return w[23 -: FracBits];
  endfunction

endpackage

### design/fvn_if.sv
// fvn_if: valid/ready channel carrying one payload item
// depends on nothing but the payload type given as parameter
interface fvn_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/fvn_octave.sv
// fvn_octave: one octave of value noise, pipelined over several stages
// depends on fvn_pkg; stall enable shared with the rest of the pipe
module fvn_octave (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [fvn_pkg::CoordW-1:0]   x_i,
  input  logic signed [fvn_pkg::CoordW-1:0]   z_i,
  input  logic [31:0]                         freq_i,
  input  logic [31:0]                         seed_i,
  output fvn_pkg::q_t                         n_o
);
  import fvn_pkg::*;

  // stage 1: scale position
  logic [63:0] px_q, pz_q;
  logic [31:0] seed1_q;
  // stage 2: corner pre-hash, fraction squares
  logic [31:0] hx0_q, hx1_q, hz0_q, hz1_q, hs_q;
  logic [FracBits-1:0] tx2_q, tz2_q, tx_q, tz_q;
  // stage 3: first hash sums, cubes
  logic [31:0] h_a_q [4];
  logic [FracBits-1:0] tx3_q, tz3_q;
  logic [37:0] pxp_q, pzp_q;
  // stage 4: second multiply, fade
  logic [31:0] h_b_q [4];
  logic [FracBits:0] fx_q, fz_q;
  // stage 5: first lerp pair
  q_t i0_q, i1_q, fz5_q;
  // stage 6: last lerp
  q_t n_q;

  localparam logic [63:0] One = 64'd1 << FracBits;

  logic [63:0] fx_d, fz_d;
  logic [63:0] px2, pz2;
  logic [31:0] cx, cz;
  logic [63:0] t2x, t2z, t3x, t3z, ppx, ppz;
  logic [31:0] hh [4];
  logic [31:0] hm [4];

  always_comb begin
    cx = px_q[47:16];
    cz = pz_q[47:16];
    t2x = (64'(to_q(px_q[15:0])) * 64'(to_q(px_q[15:0]))) >> FracBits;
    t2z = (64'(to_q(pz_q[15:0])) * 64'(to_q(pz_q[15:0]))) >> FracBits;
    t3x = (64'(tx2_q) * 64'(tx_q)) >> FracBits;
    t3z = (64'(tz2_q) * 64'(tz_q)) >> FracBits;
    ppx = (64'd6 * 64'(tx_q) * 64'(tx_q) + 64'd10 * One * One
           - 64'd15 * 64'(tx_q) * One) >> FracBits;
    ppz = (64'd6 * 64'(tz_q) * 64'(tz_q) + 64'd10 * One * One
           - 64'd15 * 64'(tz_q) * One) >> FracBits;
    hh[0] = hx0_q + hz0_q + hs_q;
    hh[1] = hx1_q + hz0_q + hs_q;
    hh[2] = hx0_q + hz1_q + hs_q;
    hh[3] = hx1_q + hz1_q + hs_q;
    for (int i = 0; i < 4; i++) begin
      hm[i] = (h_a_q[i] ^ (h_a_q[i] >> 13)) * HashMf;
    end
    fx_d = (64'(tx3_q) * 64'(pxp_q)) >> FracBits;
    fz_d = (64'(tz3_q) * 64'(pzp_q)) >> FracBits;
    px2 = 64'(signed'(x_i)) * 64'(freq_i);
    pz2 = 64'(signed'(z_i)) * 64'(freq_i);
  end

  function automatic q_t corner(input logic [31:0] h);
    logic [31:0] g;
    g = h ^ (h >> 16);
    return q_t'(to_q(g[15:0]));
  endfunction

  function automatic q_t lerp(input q_t a, input q_t b, input logic [FracBits:0] t);
    logic [63:0] s;
    s = (64'(a) * (One - 64'(t)) + 64'(b) * 64'(t)) >> FracBits;
    return s[QW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= px2;
      pz_q <= pz2;
      seed1_q <= seed_i;
      hx0_q <= cx * HashMx;
      hx1_q <= (cx + 32'd1) * HashMx;
      hz0_q <= cz * HashMz;
      hz1_q <= (cz + 32'd1) * HashMz;
      hs_q  <= seed1_q * HashMs;
      tx_q  <= to_q(px_q[15:0]);
      tz_q  <= to_q(pz_q[15:0]);
      tx2_q <= t2x[FracBits-1:0];
      tz2_q <= t2z[FracBits-1:0];
      for (int i = 0; i < 4; i++) h_a_q[i] <= hh[i];
      tx3_q <= t3x[FracBits-1:0];
      tz3_q <= t3z[FracBits-1:0];
      pxp_q <= ppx[37:0];
      pzp_q <= ppz[37:0];
      for (int i = 0; i < 4; i++) h_b_q[i] <= hm[i];
      fx_q <= fx_d[FracBits:0];
      fz_q <= fz_d[FracBits:0];
      i0_q <= lerp(corner(h_b_q[0]), corner(h_b_q[1]), fx_q);
      i1_q <= lerp(corner(h_b_q[2]), corner(h_b_q[3]), fx_q);
      fz5_q <= q_t'(fz_q);
      n_q <= lerp(i0_q, i1_q, fz5_q);
    end
  end

  assign n_o = n_q;
endmodule

### design/fractal_value_noise_height_top.sv
// fractal_value_noise_height_top: fBm value noise terrain height, deep pipeline
// depends on fvn_pkg, fvn_if, fvn_octave
//
//  channel  dir  payload                         accept
//  in_if    in   x_coord[21] z_coord[21]         valid & ready
//  out_if   out  height[9] noise_level[16]       valid & ready
//  cfg      in   cfg_we_i cfg_idx_i cfg_data_i   cfg_we_i
//
// one item per cycle while the output does not stall (6 octave stages, 3 combine stages)
// all octaves run side by side, each with its own multipliers
// reset clears valid bits and loads register defaults
// a stall at the output freezes the whole pipe; ready is out ready or empty head
module fractal_value_noise_height_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fvn_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [fvn_pkg::CfgDataW-1:0]   cfg_data_i,
  fvn_if.sink                            in_if,
  fvn_if.source                          out_if
);
  import fvn_pkg::*;

  localparam int unsigned OctLat = 6;
  localparam int unsigned Lat    = OctLat + 3;

  cfg_t cfg_q;
  logic [Lat-1:0] vld_q;
  logic en;

  assign en = out_if.ready | ~vld_q[Lat-1];
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.height_base <= 8'sd2;
      cfg_q.height_range <= 6'd10;
      cfg_q.seed_base <= 32'd1337;
      cfg_q.base_frequency <= 16'd2949;
    end else if (cfg_we_i) begin
      // indexes beyond the last register are ignored
      unique case (cfg_idx_i)
        RegHeightBase:  cfg_q.height_base <= cfg_data_i[7:0];
        RegHeightRange: cfg_q.height_range <= cfg_data_i[5:0];
        RegSeedBase:    cfg_q.seed_base <= cfg_data_i;
        RegBaseFreq:    cfg_q.base_frequency <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_if.valid};
    end
  end

  q_t n [Octaves];
  for (genvar k = 0; k < Octaves; k++) begin : g_oct
    fvn_octave u_oct (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (in_if.data[2*CoordW-1:CoordW]),
      .z_i   (in_if.data[CoordW-1:0]),
      .freq_i(32'(cfg_q.base_frequency) << k),
      .seed_i(cfg_q.seed_base + SeedStep * 32'(k)),
      .n_o   (n[k])
    );
  end

  localparam int unsigned AccW = QW + Octaves;
  localparam logic [AccW-1:0] Den = AccW'((1 << Octaves) - 1);
  // reciprocal of den, 2^RecSh/den rounded up
  localparam int unsigned RecSh = AccW + 4;
  localparam logic [RecSh:0] Rec = (RecSh+1)'(((64'd1 << RecSh) + 64'(Den) - 1) / 64'(Den));

  logic [AccW-1:0] acc_q, acc_d;
  logic [QW-1:0]   noise_q, noise_d;
  logic [QW+5:0]   prod_q;
  logic [15:0]     lvl_q;
  logic [2*AccW+4:0] qm;
  logic [AccW-1:0] qv, rem;
  logic [31:0]     lvl_d;
  logic [QW+5:0]   r;
  logic [8:0]      h;

  always_comb begin
    acc_d = '0;
    for (int k = 0; k < Octaves; k++) acc_d += AccW'(n[k]) << (Octaves - 1 - k);
    acc_d = acc_d + (Den >> 1);
    qm = (2*AccW+5)'(acc_q) * (2*AccW+5)'(Rec);
    qv = AccW'(qm >> RecSh);
    rem = acc_q - qv * Den;
    if (rem >= Den) qv = qv + AccW'(1);
    else if (rem[AccW-1]) qv = qv - AccW'(1);
    noise_d = qv[QW-1:0];
    lvl_d = (32'(noise_q) << 16) >> FracBits;
    r = (prod_q + (QW+6)'(1 << (FracBits-1))) >> FracBits;
    h = 9'(signed'(cfg_q.height_base)) + r[8:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      acc_q <= acc_d;
      noise_q <= noise_d;
      prod_q <= (QW+6)'(noise_q) * (QW+6)'(cfg_q.height_range);
      lvl_q <= lvl_d[15:0];
    end
  end

  assign out_if.valid = vld_q[Lat-1];
  assign out_if.data = {h, lvl_q};
endmodule

### design/fvn_checker.sv
// fvn_checker: port-level assertions for the fractal value noise top
// depends on fvn_pkg; bound to fractal_value_noise_height_top
module fvn_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [24:0] out_data
);
  import fvn_pkg::*;

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready |-> in_ready) else $error("input stalled while output free");
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled item changed");
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready) else $error("input taken while pipe blocked");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(out_data[24:16] == 9'h0ff)) else $error("height out of range");
endmodule

bind fractal_value_noise_height_top fvn_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_data(out_if.data)
);

### bench/fvn_tb_types.sv
// fvn_tb_types: payload structs for the bench channels of the fractal noise block
// depends on nothing; field order follows the channel table of the top level
package fvn_tb_types;

  typedef struct packed {
    logic signed [20:0] x_coord;
    logic signed [20:0] z_coord;
  } coord_t;

  typedef struct packed {
    logic signed [8:0] height;
    logic [15:0]       noise_level;
  } height_t;

endpackage

### bench/fractal_value_noise_height_top_tb.sv
// fractal_value_noise_height_top_tb: checks terrain height and noise level per coordinate
// against a behavioral fBm predictor; depends on fvn_pkg, fvn_if, fvn_tb_types and the rtl
module fractal_value_noise_height_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fvn_pkg::*;
  import fvn_tb_types::*;

  // an index past the last register
  localparam logic [CfgIdxW-1:0] RegUnused = CfgIdxW'(4);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  fvn_if #(.payload_t(coord_t)) coord_ch ();
  fvn_if #(.payload_t(height_t)) height_ch ();

  fractal_value_noise_height_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(coord_ch.sink), .out_if(height_ch.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // bench copy of the registers
  logic signed [7:0] m_base = 8'sd2;
  logic [5:0]        m_range = 6'd10;
  logic [31:0]       m_seed = 32'd1337;
  logic [15:0]       m_freq = 16'd2949;

  height_t expected_heights[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int cycles = 0;
  bit no_idle = 1'b0;
  bit hold_start = 1'b0;
  int hold_left = 0;

  initial begin
    coord_ch.valid = 1'b0;
    coord_ch.data = '0;
    height_ch.ready = 1'b0;
  end

  function automatic logic [15:0] corner_value(logic [31:0] cx, logic [31:0] cz,
                                               logic [31:0] seed);
    logic [31:0] h;
    h = cx * HashMx + cz * HashMz + seed * HashMs;
    h = (h ^ (h >> 13)) * HashMf;
    h = h ^ (h >> 16);
    return h[15:0];
  endfunction

  function automatic longint unsigned quintic(longint unsigned t);
    longint unsigned t2, t3, p;
    t2 = (t * t) >> 16;
    t3 = (t2 * t) >> 16;
    p = (6 * t * t + 10 * (64'd1 << 32) - 15 * t * (64'd1 << 16)) >> 16;
    return (t3 * p) >> 16;
  endfunction

  function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                            longint unsigned t);
    return (a * ((64'd1 << 16) - t) + b * t) >> 16;
  endfunction

  function automatic height_t terrain_height(coord_t c);
    longint xs, zs, f, px, pz;
    longint unsigned acc, tx, tz, i0, i1, n, noise, r;
    logic [31:0] cx, cz, seed;
    height_t res;
    xs = longint'(c.x_coord);
    zs = longint'(c.z_coord);
    acc = 0;
    for (int k = 0; k < Octaves; k++) begin
      f = longint'(m_freq) << k;
      px = xs * f;
      pz = zs * f;
      cx = px[47:16];
      cz = pz[47:16];
      tx = quintic(longint'(px[15:0]));
      tz = quintic(longint'(pz[15:0]));
      seed = m_seed + SeedStep * k;
      i0 = blend(corner_value(cx, cz, seed), corner_value(cx + 1, cz, seed), tx);
      i1 = blend(corner_value(cx, cz + 1, seed), corner_value(cx + 1, cz + 1, seed), tx);
      n = blend(i0, i1, tz);
      acc += n << (Octaves - 1 - k);
    end
    noise = (acc + 7) / 15;
    r = (noise * m_range + 32768) >> 16;
    res.height = 9'(longint'(m_base) + longint'(r));
    res.noise_level = noise[15:0];
    return res;
  endfunction

  task automatic send_coord(logic [20:0] x, logic [20:0] z);
    coord_t c;
    c.x_coord = x;
    c.z_coord = z;
    if (!no_idle) begin
      while ($urandom_range(99) < 34) begin
        coord_ch.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    coord_ch.valid <= 1'b1;
    coord_ch.data <= c;
    @(posedge clk_i);
    while (!coord_ch.ready) @(posedge clk_i);
    expected_heights = {expected_heights, terrain_height(c)};
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    coord_ch.valid <= 1'b0;
    while (expected_heights.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic set_regs(logic [7:0] base, logic [5:0] rng, logic [31:0] seed,
                          logic [15:0] freq);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= RegHeightBase;
    cfg_data_i <= {24'd0, base};
    @(negedge clk_i);
    cfg_idx_i <= RegHeightRange;
    cfg_data_i <= {26'd0, rng};
    @(negedge clk_i);
    cfg_idx_i <= RegSeedBase;
    cfg_data_i <= seed;
    @(negedge clk_i);
    cfg_idx_i <= RegBaseFreq;
    cfg_data_i <= {16'd0, freq};
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    m_base = base;
    m_range = rng;
    m_seed = seed;
    m_freq = freq;
    @(negedge clk_i);
  endtask

  function automatic logic [20:0] rand_coord();
    if ($urandom_range(3) == 0) return 21'($urandom);
    return 21'($signed($urandom_range(4000)) - 2000);
  endfunction

  task automatic test_reset_defaults();
    send_coord(21'd0, 21'd0);
    send_coord(21'd1, 21'd1);
    send_coord(21'sd100, -21'sd37);
    send_coord(21'h0FFFFF, 21'h100000);
  endtask

  task automatic test_extremes();
    set_regs(8'h80, 6'd63, 32'h8000_0000, 16'hFFFF);
    send_coord(21'h0FFFFF, 21'h0FFFFF);
    send_coord(21'h100000, 21'h100000);
    send_coord(21'h1FFFFF, 21'd0);
    send_coord(21'h155555, 21'h0AAAAA);
    set_regs(8'h7F, 6'd63, 32'h7FFF_FFFF, 16'd1);
    send_coord(21'h0FFFFF, 21'h100000);
    send_coord(-21'sd1, 21'd1);
    // zero frequency samples the origin cell for any coordinate
    set_regs(8'hC0, 6'd0, 32'hFFFF_FFFF, 16'd0);
    send_coord(21'h0ABCDE, 21'h154321);
    send_coord(21'h100000, 21'h0FFFFF);
    set_regs(8'hBF, 6'd40, 32'd0, 16'h8000);
    send_coord(21'h0FFFFF, -21'sd1);
    send_coord(21'h100000, 21'd0);
  endtask

  // a write past the last register leaves every register as it was
  task automatic test_unused_index();
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= RegUnused;
    cfg_data_i <= 32'hFFFF_FFFF;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    send_coord(21'sd100, -21'sd37);
    send_coord(21'h0FFFFF, 21'h100000);
  endtask

  task automatic test_random_configs();
    for (int phase = 0; phase < 8; phase++) begin
      set_regs(8'($urandom), 6'($urandom), $urandom,
               (phase % 3 == 0) ? 16'($urandom_range(1, 8000)) : 16'($urandom));
      no_idle = (phase == 4);
      for (int i = 0; i < 240; i++) send_coord(rand_coord(), rand_coord());
      no_idle = 1'b0;
    end
  endtask

  task automatic test_output_stall();
    drain();
    hold_start = 1'b1;
    no_idle = 1'b1;
    for (int i = 0; i < 60; i++) send_coord(rand_coord(), rand_coord());
    no_idle = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left = 150;
    end
    if (hold_left > 0) begin
      hold_left--;
      height_ch.ready <= 1'b0;
    end else if (no_idle) begin
      height_ch.ready <= 1'b1;
    end else begin
      height_ch.ready <= ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk_i) begin
    height_t want;
    if (rst_ni && height_ch.valid && height_ch.ready) begin
      if (expected_heights.size() == 0) begin
        $error("result with nothing expected: height %0d", height_ch.data.height);
        errors++;
      end else begin
        want = expected_heights.pop_front();
        n_checked++;
        if (height_ch.data.height !== want.height) begin
          $error("height expected %0d actual %0d", want.height, height_ch.data.height);
          errors++;
        end
        if (height_ch.data.noise_level !== want.noise_level) begin
          $error("noise_level expected %0d actual %0d", want.noise_level,
                 height_ch.data.noise_level);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 600000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_extremes();
    test_unused_index();
    test_random_configs();
    test_output_stall();
    drain();
    if (expected_heights.size() != 0) errors++;
    $display("sent %0d coordinates under reset, fixed and random register values, checked %0d",
             n_sent, n_checked);
    $display("covered extremes, zero frequency, cell wrap, an unused index and a long stall");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
